/* src/shape_pair_collision_test_macros.svh */
// Assertion macros shared by the shape pair collision test RTL.
`ifndef SHAPE_PAIR_COLLISION_TEST_MACROS_SVH
`define SHAPE_PAIR_COLLISION_TEST_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, switched off while reset is asserted
`define SPCT_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
		else $error("spct assertion failed");
// Clocked check that also holds during reset
`define SPCT_ASSERT_RST(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("spct reset assertion failed");
`else
`define SPCT_ASSERT(lbl, clk, rst_n, prop)
`define SPCT_ASSERT_RST(lbl, clk, prop)
`endif
`endif

/* src/spct_pkg.sv */
// Package: shared types and constants of the shape pair collision test.
`timescale 1ns / 1ps
package spct_pkg;

	// field widths
	localparam int COORD_W      = 20;  // Q16.4 signed centre
	localparam int HALF_W       = 16;  // Q12.4 unsigned half extent
	localparam int LAYER_W      = 8;   // layer mask of shape A
	localparam int TYPE_W       = 3;   // type index of shape B
	localparam int DIFF_W       = 22;  // signed working width for bounds and gaps
	localparam int MAG_W        = 21;  // per-axis distance magnitude
	localparam int RAD_W        = HALF_W + 1;
	localparam int SQ_W         = 2 * MAG_W + 1;
	localparam int RR_W         = 2 * RAD_W;
	localparam int NUM_TYPES_DEF = 8;

	// input tdata: packed fields, zero padded to whole bytes
	localparam int PAIR_BITS    = 4 * COORD_W + 4 * HALF_W + LAYER_W + TYPE_W;
	localparam int PAIR_W       = ((PAIR_BITS + 7) / 8) * 8;

	// shape kind codes; code three means inactive
	typedef enum logic [1:0] {
		MODE_OFF    = 2'd0,
		MODE_BOX    = 2'd1,
		MODE_CIRCLE = 2'd2
	} shape_mode_t;

	// prepared pair, handed from the geometry stage to the distance stage
	typedef struct packed {
		logic              act;     // both active and layers permit
		logic              box_box; // decided by the overlap test
		logic              bb_hit;
		logic [MAG_W-1:0]  ex;
		logic [MAG_W-1:0]  ey;
		logic [RAD_W-1:0]  rad;
	} prep_t;

endpackage

/* src/spct_prep.sv */
// Geometry stage: kind decode, box overlap test and per-axis gaps for the circle tests.
`timescale 1ns / 1ps
module spct_prep (
	input  logic [1:0]                            a_mode,
	input  logic signed [spct_pkg::COORD_W-1:0]   a_x,
	input  logic signed [spct_pkg::COORD_W-1:0]   a_y,
	input  logic [spct_pkg::HALF_W-1:0]           a_half_w,
	input  logic [spct_pkg::HALF_W-1:0]           a_half_h,
	input  logic [1:0]                            b_mode,
	input  logic signed [spct_pkg::COORD_W-1:0]   b_x,
	input  logic signed [spct_pkg::COORD_W-1:0]   b_y,
	input  logic [spct_pkg::HALF_W-1:0]           b_half_w,
	input  logic [spct_pkg::HALF_W-1:0]           b_half_h,
	input  logic                                  layer_ok,
	output spct_pkg::prep_t                       prep
);

	localparam int DW = spct_pkg::DIFF_W;
	localparam int MW = spct_pkg::MAG_W;
	localparam int RW = spct_pkg::RAD_W;
	localparam int HALF_W_LOCAL = spct_pkg::HALF_W;

	// distance from c to the closed interval [ctr-half, ctr+half]
	function automatic logic [MW-1:0] gap(input logic signed [DW-1:0] c,
		input logic signed [DW-1:0] ctr, input logic signed [DW-1:0] half);
		logic signed [DW-1:0] lo;
		logic signed [DW-1:0] hi;
		logic signed [DW-1:0] d;
		lo = ctr - half;
		hi = ctr + half;
		if (c < lo) begin
			d = lo - c;
		end else if (c > hi) begin
			d = c - hi;
		end else begin
			d = '0;
		end
		return d[MW-1:0];
	endfunction

	// magnitude of a signed difference
	function automatic logic [MW-1:0] mag(input logic signed [DW-1:0] d);
		logic signed [DW-1:0] m;
		m = (d < 0) ? -d : d;
		return m[MW-1:0];
	endfunction

	logic a_on, b_on, a_box, b_box, a_circ, b_circ;
	logic signed [DW-1:0] ax, ay, bx, by, aw, ah, bw, bh;
	logic signed [DW-1:0] box_x, box_y, box_w, box_h, cir_x, cir_y;
	logic [MW-1:0] adx, ady, gx, gy;
	logic [RW-1:0] wsum, hsum, rsum;
	logic [HALF_W_LOCAL-1:0] cir_r;

	// kind decode; code three falls out as inactive
	always_comb begin
		a_box  = (a_mode == spct_pkg::MODE_BOX);
		a_circ = (a_mode == spct_pkg::MODE_CIRCLE);
		b_box  = (b_mode == spct_pkg::MODE_BOX);
		b_circ = (b_mode == spct_pkg::MODE_CIRCLE);
		a_on   = a_box | a_circ;
		b_on   = b_box | b_circ;
	end

	// widen to the working width
	assign ax = DW'(a_x);
	assign ay = DW'(a_y);
	assign bx = DW'(b_x);
	assign by = DW'(b_y);
	assign aw = signed'(DW'(a_half_w));
	assign ah = signed'(DW'(a_half_h));
	assign bw = signed'(DW'(b_half_w));
	assign bh = signed'(DW'(b_half_h));

	// centre distances and summed extents
	assign adx  = mag(ax - bx);
	assign ady  = mag(ay - by);
	assign wsum = RW'(a_half_w) + RW'(b_half_w);
	assign hsum = RW'(a_half_h) + RW'(b_half_h);
	assign rsum = wsum;

	// pick which shape is the box for the mixed test
	always_comb begin
		if (a_box) begin
			box_x = ax; box_y = ay; box_w = aw; box_h = ah;
			cir_x = bx; cir_y = by; cir_r = b_half_w;
		end else begin
			box_x = bx; box_y = by; box_w = bw; box_h = bh;
			cir_x = ax; cir_y = ay; cir_r = a_half_w;
		end
	end

	assign gx = gap(cir_x, box_x, box_w);
	assign gy = gap(cir_y, box_y, box_h);

	// pack the prepared pair
	always_comb begin
		prep.act     = a_on & b_on & layer_ok;
		prep.box_box = a_box & b_box;
		prep.bb_hit  = (MW'(adx) < MW'(wsum)) && (MW'(ady) < MW'(hsum));
		if (a_circ && b_circ) begin
			prep.ex  = adx;
			prep.ey  = ady;
			prep.rad = rsum;
		end else begin
			prep.ex  = gx;
			prep.ey  = gy;
			prep.rad = RW'(cir_r);
		end
	end

endmodule

/* src/shape_pair_collision_test.sv */
// Pipeline: a pair's hit flag passes through the input, geometry and result registers in turn before it is presented.
// Throughput: one pair per cycle; the three-register pipeline stalls only under output backpressure.
// Per-stage depth is set by the 21x21 squares and compare in the last stage.
// Reset: arst_n clears all valid flags asynchronously; payload registers are not reset.
// Output tdata bit 0 is the hit flag, the other bits read zero.
`timescale 1ns / 1ps
`include "shape_pair_collision_test_macros.svh"
module shape_pair_collision_test #(
	parameter int NUM_TYPES = spct_pkg::NUM_TYPES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	// input pair
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	// a_x, a_y, a_half_w, a_half_h, a_layers, b_type, b_x, b_y, b_half_w, b_half_h, zero pad
	input  logic [spct_pkg::PAIR_W-1:0]   s_axis_tdata,
	// a_mode, b_mode
	input  logic [3:0]                    s_axis_tuser,
	// result
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	// hit, zero pad
	output logic [7:0]                    m_axis_tdata
);

	localparam int CW     = spct_pkg::COORD_W;
	localparam int HW     = spct_pkg::HALF_W;
	localparam int LW     = spct_pkg::LAYER_W;
	localparam int TYPE_W = spct_pkg::TYPE_W;
	localparam int MW     = spct_pkg::MAG_W;
	localparam int RW     = spct_pkg::RAD_W;
	// field offsets in tdata
	localparam int O_AX = 0;
	localparam int O_AY = O_AX + CW;
	localparam int O_AW = O_AY + CW;
	localparam int O_AH = O_AW + HW;
	localparam int O_AL = O_AH + HW;
	localparam int O_BT = O_AL + LW;
	localparam int O_BX = O_BT + TYPE_W;
	localparam int O_BY = O_BX + CW;
	localparam int O_BW = O_BY + CW;
	localparam int O_BH = O_BW + HW;

	// input register
	logic                     v_s1;
	logic [1:0]               a_mode_s1, b_mode_s1;
	logic signed [CW-1:0]     a_x_s1, a_y_s1, b_x_s1, b_y_s1;
	logic [HW-1:0]            a_half_w_s1, a_half_h_s1, b_half_w_s1, b_half_h_s1;
	logic [LW-1:0]            a_layers_s1;
	logic [TYPE_W-1:0]        b_type_s1;

	// geometry register
	logic                     v_s2;
	spct_pkg::prep_t          prep_c, prep_s2;

	// result register
	logic                     out_valid_q;
	logic                     hit_q;

	logic out_en, s2_en, s1_en;
	logic type_ok, layer_ok;
	logic [2*MW-1:0] ex_sq, ey_sq;
	logic [spct_pkg::SQ_W-1:0] dist_sq;
	logic [spct_pkg::RR_W-1:0] rad_sq;
	logic hit_c;

	// stage advance: a stage moves when the one after it is free or moving
	assign out_en        = !out_valid_q || m_axis_tready;
	assign s2_en         = !v_s2 || out_en;
	assign s1_en         = !v_s1 || s2_en;
	assign s_axis_tready = s1_en;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_en) begin
				v_s1 <= s_axis_tvalid;
			end
			if (s2_en) begin
				v_s2 <= v_s1;
			end
			if (out_en) begin
				out_valid_q <= v_s2;
			end
		end
	end

	// capture the transaction
	always_ff @(posedge clk) begin
		if (s1_en && s_axis_tvalid) begin
			a_mode_s1   <= s_axis_tuser[1:0];
			b_mode_s1   <= s_axis_tuser[3:2];
			a_x_s1      <= s_axis_tdata[O_AX +: CW];
			a_y_s1      <= s_axis_tdata[O_AY +: CW];
			a_half_w_s1 <= s_axis_tdata[O_AW +: HW];
			a_half_h_s1 <= s_axis_tdata[O_AH +: HW];
			a_layers_s1 <= s_axis_tdata[O_AL +: LW];
			b_type_s1   <= s_axis_tdata[O_BT +: TYPE_W];
			b_x_s1      <= s_axis_tdata[O_BX +: CW];
			b_y_s1      <= s_axis_tdata[O_BY +: CW];
			b_half_w_s1 <= s_axis_tdata[O_BW +: HW];
			b_half_h_s1 <= s_axis_tdata[O_BH +: HW];
		end
	end

	// layer mask test; a type beyond the type count never permits
	assign type_ok  = ({3'b0, b_type_s1} < 6'(NUM_TYPES));
	assign layer_ok = type_ok && a_layers_s1[b_type_s1];

	spct_prep u_prep (
		.a_mode   (a_mode_s1),
		.a_x      (a_x_s1),
		.a_y      (a_y_s1),
		.a_half_w (a_half_w_s1),
		.a_half_h (a_half_h_s1),
		.b_mode   (b_mode_s1),
		.b_x      (b_x_s1),
		.b_y      (b_y_s1),
		.b_half_w (b_half_w_s1),
		.b_half_h (b_half_h_s1),
		.layer_ok (layer_ok),
		.prep     (prep_c)
	);

	always_ff @(posedge clk) begin
		if (s2_en && v_s1) begin
			prep_s2 <= prep_c;
		end
	end

	// squared distance against squared radius, or the overlap test for two boxes; upper operand halves are zero
	assign ex_sq   = {{MW{1'b0}}, prep_s2.ex} * {{MW{1'b0}}, prep_s2.ex};
	assign ey_sq   = {{MW{1'b0}}, prep_s2.ey} * {{MW{1'b0}}, prep_s2.ey};
	assign dist_sq = spct_pkg::SQ_W'(ex_sq) + spct_pkg::SQ_W'(ey_sq);
	assign rad_sq  = {{RW{1'b0}}, prep_s2.rad} * {{RW{1'b0}}, prep_s2.rad};
	assign hit_c   = prep_s2.act
		&& (prep_s2.box_box ? prep_s2.bb_hit : (dist_sq <= spct_pkg::SQ_W'(rad_sq)));

	always_ff @(posedge clk) begin
		if (out_en && v_s2) begin
			hit_q <= hit_c;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {7'b0, hit_q};

	// checks
	`SPCT_ASSERT(a_inactive_miss, clk, arst_n, (v_s2 && out_en && !prep_s2.act) |=> (hit_q == 1'b0))
	`SPCT_ASSERT(a_s1_moves, clk, arst_n, (v_s1 && s2_en) |=> v_s2)
	`SPCT_ASSERT(a_empty_ready, clk, arst_n, (!out_valid_q) |-> s_axis_tready)
	`SPCT_ASSERT_RST(a_reset_quiet, clk, (!arst_n) |-> (!m_axis_tvalid))

endmodule
